[sv/idsa_pkg.sv]
// shared types, constants and register indexes for the 2x2 average downscaler
`timescale 1ns / 1ps
`default_nettype none
package idsa_pkg;

    localparam int NCH = 4;
    localparam int PIX_W = 8;
    localparam int SUM_W = PIX_W + 1;
    localparam int CFG_W = 13;
    localparam int CC_W = 3;
    localparam int IDX_W = 2;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RST_WIDTH = 640;
    localparam int RST_HEIGHT = 480;
    localparam logic [CC_W-1:0] RST_CC = CC_W'(NCH);

    localparam logic [IDX_W-1:0] CFG_SRC_WIDTH = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef logic [NCH-1:0][PIX_W-1:0] t_pix;
    typedef logic [NCH-1:0][SUM_W-1:0] t_sums;

    typedef struct packed {
        t_sums sum;
        logic  odd_row;
        logic  eor;
        logic  eof;
    } t_job;

endpackage
`default_nettype wire

[sv/idsa_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module idsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/idsa_front.sv]
// input stage: raster counters, held pixel, pair sums, line store access
`timescale 1ns / 1ps
`default_nettype none
module idsa_front
    import idsa_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2,
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire t_pix            i_pix,
    input  wire logic [CW-1:0]   i_w_last,
    input  wire logic [RW-1:0]   i_h_last,
    input  wire logic [CC_W-1:0] i_cc,
    input  wire logic            i_restart,
    input  wire logic            i_adv,
    output logic                 o_s1_valid,
    output t_job                 o_job,
    output logic                 o_we,
    output logic                 o_re,
    output logic [AW-1:0]        o_addr,
    output t_sums                o_wdata
);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    t_pix          r_held;
    logic          r_s1_valid;
    t_job          r_job;

    logic  accept, last_col, last_row, have_pair, emit;
    t_pix  pix;
    t_sums sum;

    assign o_stall   = r_s1_valid && !i_adv;
    assign accept    = i_valid && !o_stall;
    assign last_col  = (r_col == i_w_last);
    assign last_row  = (r_row == i_h_last);
    assign have_pair = r_col[0] || last_col;
    assign emit      = have_pair && (r_row[0] || last_row);

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            pix[c] = (CC_W'(c) < i_cc) ? i_pix[c] : '0;
            if (r_col[0]) begin
                sum[c] = SUM_W'(r_held[c]) + SUM_W'(pix[c]);
            end else begin
                sum[c] = {pix[c], 1'b0};
            end
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    assign o_we    = accept && have_pair && !r_row[0];
    assign o_re    = accept && have_pair && r_row[0];
    assign o_addr  = AW'(r_col >> 1);
    assign o_wdata = sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept && !r_col[0]) begin
                r_held <= pix;
            end
            if (i_adv || !r_s1_valid) begin
                r_s1_valid <= accept && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_job.sum     <= sum;
            r_job.odd_row <= r_row[0];
            r_job.eor     <= last_col;
            r_job.eof     <= last_col && last_row;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_job      = r_job;

endmodule
`default_nettype wire

[sv/idsa_back.sv]
// output stage: completes the 2x2 mean (the pair mean on an unpaired last row) and holds the result beat
`timescale 1ns / 1ps
`default_nettype none
module idsa_back
    import idsa_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s1_valid,
    input  wire t_job            i_job,
    input  wire t_sums           i_top,
    input  wire logic [CC_W-1:0] i_cc,
    output logic                 o_adv,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output t_pix                 o_pix,
    output logic                 o_eor,
    output logic                 o_eof
);

    logic                r_valid;
    t_pix                r_pix;
    logic                r_eor;
    logic                r_eof;
    t_pix                mean;
    logic [SUM_W:0]      full;
    logic [SUM_W-1:0]    half;

    assign o_adv = !r_valid || !i_stall;

    always_comb begin
        mean = '0;
        full = '0;
        half = '0;
        for (int c = 0; c < NCH; c++) begin
            full = (SUM_W+1)'(i_top[c]) + (SUM_W+1)'(i_job.sum[c]) + (SUM_W+1)'(2);
            half = i_job.sum[c] + SUM_W'(1);
            if (CC_W'(c) < i_cc) begin
                mean[c] = i_job.odd_row ? full[SUM_W:2] : half[SUM_W-1:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_s1_valid) begin
            r_pix <= mean;
            r_eor <= i_job.eor;
            r_eof <= i_job.eof;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_eor   = r_eor;
    assign o_eof   = r_eof;

endmodule
`default_nettype wire

[sv/image_downscale_2x2_average.sv]
// top level of the 2x2 box-filter downscaler
// the beat that completes a 2x2 block is registered into the front job register, then its mean into the output register
// throughput: one input pixel per cycle unless o_stall is raised while the output stage is held by i_stall
// reset: counters restart at the frame origin, 640x480 with four channels,
// the line store needs no clearing and the block is ready right after reset
`timescale 1ns / 1ps
`default_nettype none
module image_downscale_2x2_average
    import idsa_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [PIX_W-1:0] i_in_ch0,
    input  wire logic [PIX_W-1:0] i_in_ch1,
    input  wire logic [PIX_W-1:0] i_in_ch2,
    input  wire logic [PIX_W-1:0] i_in_ch3,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [PIX_W-1:0]      o_out_ch0,
    output logic [PIX_W-1:0]      o_out_ch1,
    output logic [PIX_W-1:0]      o_out_ch2,
    output logic [PIX_W-1:0]      o_out_ch3,
    output logic                  o_end_of_row,
    output logic                  o_end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int RST_W_LAST = ((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH) - 1;
    localparam int RST_H_LAST = ((RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT) - 1;

    logic [CW-1:0]   r_w_last;
    logic [RW-1:0]   r_h_last;
    logic [CC_W-1:0] r_cc;
    logic [CW-1:0]   n_w_last;
    logic [RW-1:0]   n_h_last;
    logic [CC_W-1:0] n_cc;
    logic [31:0]     cfg_val, w_eff, h_eff;
    logic            restart;

    always_comb begin
        cfg_val = 32'(i_cfg_data);
        if (cfg_val == 32'd0) begin
            w_eff = 32'd1;
        end else if (cfg_val > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = cfg_val;
        end
        if (cfg_val == 32'd0) begin
            h_eff = 32'd1;
        end else if (cfg_val > 32'(MAX_HEIGHT)) begin
            h_eff = 32'(MAX_HEIGHT);
        end else begin
            h_eff = cfg_val;
        end
        n_w_last = CW'(w_eff - 32'd1);
        n_h_last = RW'(h_eff - 32'd1);
        if (i_cfg_data[CC_W-1:0] == '0) begin
            n_cc = CC_W'(1);
        end else if (i_cfg_data[CC_W-1:0] > CC_W'(NCH)) begin
            n_cc = CC_W'(NCH);
        end else begin
            n_cc = i_cfg_data[CC_W-1:0];
        end
    end

    assign restart = i_cfg_we && (i_cfg_index == CFG_SRC_WIDTH ||
                                  i_cfg_index == CFG_SRC_HEIGHT ||
                                  i_cfg_index == CFG_CHANNEL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(RST_W_LAST);
            r_h_last <= RW'(RST_H_LAST);
            r_cc     <= RST_CC;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:     r_w_last <= n_w_last;
                CFG_SRC_HEIGHT:    r_h_last <= n_h_last;
                CFG_CHANNEL_COUNT: r_cc     <= n_cc;
                default: ;
            endcase
        end
    end

    t_pix          in_pix, out_pix;
    t_job          job;
    t_sums         wdata, top;
    logic          s1_valid, adv, we, re;
    logic [AW-1:0] addr;

    assign in_pix = {i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0};

    idsa_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pix      (in_pix),
        .i_w_last   (r_w_last),
        .i_h_last   (r_h_last),
        .i_cc       (r_cc),
        .i_restart  (restart),
        .i_adv      (adv),
        .o_s1_valid (s1_valid),
        .o_job      (job),
        .o_we       (we),
        .o_re       (re),
        .o_addr     (addr),
        .o_wdata    (wdata)
    );

    idsa_ram #(
        .WIDTH ($bits(t_sums)),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (addr),
        .o_rdata (top)
    );

    idsa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_job      (job),
        .i_top      (top),
        .i_cc       (r_cc),
        .o_adv      (adv),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pix      (out_pix),
        .o_eor      (o_end_of_row),
        .o_eof      (o_end_of_frame)
    );

    assign o_out_ch0 = out_pix[0];
    assign o_out_ch1 = out_pix[1];
    assign o_out_ch2 = out_pix[2];
    assign o_out_ch3 = out_pix[3];

endmodule
`default_nettype wire

[verif/tb.sv]
// self-checking testbench for the 2x2 average downscaler: random frames against a pixel predictor
`timescale 1ns / 1ps
module tb
    import idsa_pkg::*;
();

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int LINE_DEPTH = (MAX_W + 1) / 2;
    localparam int PAIR_W = 10;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        t_pix pix;
        logic eor;
        logic eof;
    } t_scaled_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_pix              in_pix = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [PIX_W-1:0]  o_out_ch0, o_out_ch1, o_out_ch2, o_out_ch3;
    logic              o_end_of_row, o_end_of_frame;

    // predictor state
    logic [CFG_W-1:0]  reg_width = CFG_W'(RST_WIDTH);
    logic [CFG_W-1:0]  reg_height = CFG_W'(RST_HEIGHT);
    logic [CC_W-1:0]   reg_channels = RST_CC;
    int unsigned       cur_col = 0;
    int unsigned       cur_row = 0;
    t_pix              held_pix = '0;
    logic [NCH-1:0][PAIR_W-1:0] line_pair_sums [LINE_DEPTH];

    t_pix              pending_pixels[$];
    t_scaled_pixel     expected_pixels[$];
    int                pixels_queued = 0;
    int                pixels_accepted = 0;
    int                error_count = 0;
    int                cycle_count = 0;
    int                idle_left = 0;
    int                stall_left = 0;
    bit                tx_idle_on = 1'b0;
    bit                rx_stall_on = 1'b0;

    image_downscale_2x2_average dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_ch0       (in_pix[0]),
        .i_in_ch1       (in_pix[1]),
        .i_in_ch2       (in_pix[2]),
        .i_in_ch3       (in_pix[3]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_ch0      (o_out_ch0),
        .o_out_ch1      (o_out_ch1),
        .o_out_ch2      (o_out_ch2),
        .o_out_ch3      (o_out_ch3),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned clamp_range(input int unsigned v, lo, hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic apply_config(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_SRC_WIDTH: reg_width = data;
            CFG_SRC_HEIGHT: reg_height = data;
            CFG_CHANNEL_COUNT: reg_channels = data[CC_W-1:0];
            default: ;
        endcase
        if (idx != CFG_UNMAPPED) begin
            cur_col = 0;
            cur_row = 0;
        end
    endtask

    task automatic downscale_pixel(input t_pix raw);
        int unsigned w, h, cc, col, row, slot, top, v;
        t_pix px;
        logic [NCH-1:0][PAIR_W-1:0] sums;
        logic last_col, last_row;
        t_scaled_pixel res;
        w = clamp_range(reg_width, 1, MAX_W);
        h = clamp_range(reg_height, 1, MAX_H);
        cc = clamp_range(reg_channels, 1, NCH);
        col = (cur_col >= w) ? w - 1 : cur_col;
        row = (cur_row >= h) ? h - 1 : cur_row;
        last_col = (col == w - 1);
        last_row = (row == h - 1);
        for (int c = 0; c < NCH; c++)
            px[c] = (c < cc) ? raw[c] : '0;
        if (col % 2 == 0)
            held_pix = px;
        if (col % 2 == 1 || last_col) begin
            slot = (col >> 1) % LINE_DEPTH;
            for (int c = 0; c < NCH; c++)
                sums[c] = (col % 2 == 1) ? PAIR_W'(held_pix[c]) + PAIR_W'(px[c])
                                         : PAIR_W'(px[c]) << 1;
            if (row % 2 == 0)
                line_pair_sums[slot] = sums;
            if (row % 2 == 1 || last_row) begin
                for (int c = 0; c < NCH; c++) begin
                    top = line_pair_sums[slot][c];
                    v = (row % 2 == 1) ? (top + sums[c] + 2) >> 2 : (sums[c] + 1) >> 1;
                    res.pix[c] = (c < cc) ? v[PIX_W-1:0] : '0;
                end
                res.eor = last_col;
                res.eof = last_col && last_row;
                expected_pixels.push_back(res);
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        cur_col = col;
        cur_row = row;
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                downscale_pixel(in_pix);
                pixels_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    in_pix <= pending_pixels.pop_front();
                    i_valid <= 1'b1;
                    idle_left = tx_idle_on ? $urandom_range(0, 12) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin : monitor
        t_scaled_pixel want;
        t_pix got;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_out_ch3, o_out_ch2, o_out_ch1, o_out_ch0};
                if (expected_pixels.size() == 0) begin
                    $error("output beat with no pixel expected");
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    for (int c = 0; c < NCH; c++)
                        if (got[c] !== want.pix[c]) begin
                            $error("out_ch%0d: expected %0d, got %0d", c, want.pix[c], got[c]);
                            error_count++;
                        end
                    if (o_end_of_row !== want.eor) begin
                        $error("end_of_row: expected %0d, got %0d", want.eor, o_end_of_row);
                        error_count++;
                    end
                    if (o_end_of_frame !== want.eof) begin
                        $error("end_of_frame: expected %0d, got %0d", want.eof, o_end_of_frame);
                        error_count++;
                    end
                end
                stall_left = rx_stall_on ? $urandom_range(0, 12) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("image_downscale_2x2_average: mismatch");
            $finish;
        end
    end

    task automatic queue_pixel(input t_pix p);
        pending_pixels.push_back(p);
        pixels_queued++;
    endtask

    function automatic t_pix random_pixel();
        return t_pix'($urandom);
    endfunction

    task automatic wait_idle();
        while (pixels_accepted != pixels_queued || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_config(idx, data);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, h, ccd);
        write_register(CFG_SRC_WIDTH, w);
        write_register(CFG_SRC_HEIGHT, h);
        write_register(CFG_CHANNEL_COUNT, ccd);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] random_channels();
        if ($urandom_range(0, 3) == 0)
            return CFG_W'($urandom);
        return CFG_W'($urandom_range(0, 7));
    endfunction

    initial begin
        int unsigned mode, frame, n, target, pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default 640x480 geometry, first row only
        queue_pixel('0);
        queue_pixel('1);
        queue_pixel({NCH{8'h55}});
        queue_pixel({NCH{8'hAA}});
        wait_idle();

        // full-scale rounding, unmapped index write mid frame
        configure(2, 2, 4);
        queue_pixel('1);
        queue_pixel('1);
        wait_idle();
        write_register(CFG_UNMAPPED, '1);
        i_cfg_we <= 1'b0;
        queue_pixel('0);
        queue_pixel({8'h03, 8'h02, 8'h01, 8'h00});
        wait_idle();

        // zero width, height and channel count
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
        configure(0, 0, 0);
        repeat (2) queue_pixel(random_pixel());
        wait_idle();

        // odd width and odd height, channel count above range
        configure(3, 3, '1);
        repeat (9) queue_pixel(random_pixel());
        wait_idle();

        // height and width above range
        configure(1, '1, 3);
        repeat (2) queue_pixel(random_pixel());
        wait_idle();
        configure('1, 1, 2);
        repeat (2) queue_pixel(random_pixel());

        target = pixels_queued + RANDOM_ITEMS;
        while (pixels_queued < target) begin
            wait_idle();
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_stall_on = ($urandom_range(0, 2) != 0);
            mode = $urandom_range(0, 19);
            if (mode == 0) begin
                configure(CFG_W'($urandom_range(MAX_W - 8, 8191)),
                          ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(1, 3))
                                                      : CFG_W'($urandom_range(MAX_H - 2, 8191)),
                          random_channels());
            end else if (mode == 1) begin
                write_register(CFG_UNMAPPED, CFG_W'($urandom));
                i_cfg_we <= 1'b0;
            end else if (mode <= 4) begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    write_register(CFG_SRC_WIDTH, CFG_W'($urandom_range(0, 10)));
                else if (pick == 1)
                    write_register(CFG_SRC_HEIGHT, CFG_W'($urandom_range(0, 6)));
                else
                    write_register(CFG_CHANNEL_COUNT, random_channels());
                i_cfg_we <= 1'b0;
            end else begin
                configure(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 6)),
                          random_channels());
            end
            frame = clamp_range(reg_width, 1, MAX_W) * clamp_range(reg_height, 1, MAX_H);
            if (frame > 100)
                n = $urandom_range(1, 12);
            else if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, frame);
            else
                n = frame * $urandom_range(1, 2);
            repeat (n) queue_pixel(random_pixel());
        end
        wait_idle();

        if (error_count == 0)
            $display("image_downscale_2x2_average: match");
        else
            $display("image_downscale_2x2_average: mismatch");
        $finish;
    end

endmodule
